FILE: rtl/ccr_pkg.sv
// Package: shared constants and types for the command responder
`timescale 1ns / 1ps
package ccr_pkg;
    localparam int unsigned FREQ_W   = 30;
    localparam logic [29:0] FREQ_MAX = 30'd999999990;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;
    localparam logic [9:0]  TONE_RST    = 10'd600;
    localparam logic [8:0]  DOT_RST     = 9'd100;
    localparam logic [7:0]  DELAY_RST   = 8'd60;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_TONE    = 2'd1;
    localparam logic [1:0] CFG_DOT     = 2'd2;
    localparam logic [1:0] CFG_DELAY   = 2'd3;

    localparam logic [7:0] OP_SET_FREQ  = 8'h01;
    localparam logic [7:0] OP_SPLIT_ON  = 8'h02;
    localparam logic [7:0] OP_READ_FREQ = 8'h03;
    localparam logic [7:0] OP_MODE      = 8'h07;
    localparam logic [7:0] OP_PTT_ON    = 8'h08;
    localparam logic [7:0] OP_SWAP      = 8'h81;
    localparam logic [7:0] OP_SPLIT_OFF = 8'h82;
    localparam logic [7:0] OP_PTT_OFF   = 8'h88;
    localparam logic [7:0] OP_SETTINGS  = 8'hBB;
    localparam logic [7:0] OP_RX_STAT   = 8'hE7;
    localparam logic [7:0] OP_TX_STAT   = 8'hF7;

    // weight of BCD digit i (most significant first), tens of Hz units in Hz
    function automatic logic [26:0] digit_weight(input logic [2:0] i);
        logic [26:0] w;
        case (i)
            3'd0: w = 27'd100000000;
            3'd1: w = 27'd10000000;
            3'd2: w = 27'd1000000;
            3'd3: w = 27'd100000;
            3'd4: w = 27'd10000;
            3'd5: w = 27'd1000;
            3'd6: w = 27'd100;
            default: w = 27'd10;
        endcase
        return w;
    endfunction
endpackage

FILE: rtl/cat_command_responder.sv
// Top level: frame assembly, command sequencer and shared arithmetic unit
`timescale 1ns / 1ps
// Command responder for a five-byte serial control protocol.
// Input channel (valid/ready): command 0 carries a received byte in rx_byte,
// command 1 is a millisecond tick. Four operand bytes and an opcode byte
// form a frame; a partial frame idle past timeout_ms ticks is dropped.
// Output channel (valid/ready): one transaction per response byte, last_byte
// set on the final one, with the radio state after the command alongside.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle;
// the block does not enforce it. Ticks and operand bytes are taken in the
// idle state; after an opcode the shared unit runs: frequency set takes 8
// multiply-add steps, frequency read up to 9 subtractions plus a store per
// digit over 8 digits, then a units-digit store and packing, the tone read
// subtracts 300 then 50 repeatedly, the speed read up to 1200 subtractions
// at a dot length of 1; other opcodes need no arithmetic. Each response
// byte needs one output transaction; a stalled receiver holds the block.
// Reset clears radio state and frame counter; config registers take their
// documented defaults. No item is accepted while a response is pending.
module cat_command_responder
    import ccr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  resp_byte,
    output logic        last_byte,
    output logic        tx_active,
    output logic        usb_mode,
    output logic        split_on,
    output logic [29:0] tuned_freq,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_BCD, S_DIG, S_DIV, S_SEND} state_t;

    state_t      state_reg;
    logic [15:0] timeout_reg;
    logic [9:0]  tone_reg;
    logic [8:0]  dot_reg;
    logic [7:0]  delay_reg;
    logic [7:0]  fs_reg [4];
    logic [2:0]  cnt_reg;
    logic [15:0] idle_reg;
    logic [29:0] act_reg, oth_reg;
    logic        vfob_reg, usb_reg, split_reg, tx_reg;
    logic [7:0]  r_reg [5];
    logic [2:0]  nres_reg, k_reg;
    logic [3:0]  step_reg;
    logic [3:0]  dig_reg;
    logic [33:0] acc_reg;
    logic [10:0] quo_reg;
    logic [3:0]  d_reg [9];

    // shared unit: multiply or subtract a digit weight and compare
    logic [26:0] wt;
    logic [33:0] diff;
    logic        ge;
    logic [3:0]  nib;
    assign wt   = digit_weight((state_reg == S_DIG) ? dig_reg[2:0] : step_reg[2:0]);
    assign diff = acc_reg - {7'd0, wt};
    assign ge   = acc_reg >= {7'd0, wt};
    assign nib  = step_reg[0] ? fs_reg[step_reg[2:1]][3:0] : fs_reg[step_reg[2:1]][7:4];
    logic [30:0] prod;
    assign prod = {27'd0, nib} * {4'd0, wt};

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_SEND);
    assign resp_byte  = r_reg[k_reg];
    assign last_byte  = (k_reg == nres_reg - 3'd1);
    assign tx_active  = tx_reg;
    assign usb_mode   = usb_reg;
    assign split_on   = split_reg;
    assign tuned_freq = act_reg;

    // settings-memory read table
    function automatic logic [15:0] settings(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] v;
        v = 16'h0000;
        case (lo)
            8'h45: v = (hi == 8'h03) ? 16'h00D0 : 16'h0000;
            8'h47: v = (hi == 8'h03) ? 16'hDCE0 : 16'h0000;
            8'h55: v = {7'b1000000, vfob_reg, 8'h00};
            8'h57: v = 16'hC040;
            8'h5C: v = 16'hB242;
            8'h5E: v = 16'h0025;
            8'h61: v = 16'h2808;
            8'h5F: v = 16'h3208;
            8'h60: v = {delay_reg, 8'h32};
            8'h62: v = 16'h00B2;
            8'h63: v = 16'hB2A5;
            8'h67: v = 16'hB2B2;
            8'h69, 8'h78: v = {usb_reg ? 8'h20 : 8'h00, 8'h00};
            8'h7A: v = {split_reg ? 8'hFF : 8'h7F, 8'h00};
            8'hB3: v = 16'h004D;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            timeout_reg <= TIMEOUT_RST;
            tone_reg    <= TONE_RST;
            dot_reg     <= DOT_RST;
            delay_reg   <= DELAY_RST;
            cnt_reg     <= 3'd0;
            idle_reg    <= 16'd0;
            act_reg     <= 30'd0;
            oth_reg     <= 30'd0;
            vfob_reg    <= 1'b0;
            usb_reg     <= 1'b0;
            split_reg   <= 1'b0;
            tx_reg      <= 1'b0;
            k_reg       <= 3'd0;
            nres_reg    <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    CFG_TONE:    tone_reg    <= cfg_data[9:0];
                    CFG_DOT:     dot_reg     <= cfg_data[8:0];
                    CFG_DELAY:   delay_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        k_reg <= 3'd0;
                        if (command)
                        begin
                            if (cnt_reg != 3'd0)
                            begin
                                if (idle_reg >= timeout_reg)
                                begin
                                    cnt_reg  <= 3'd0;
                                    idle_reg <= 16'd0;
                                end
                                else
                                    idle_reg <= idle_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            idle_reg <= 16'd0;
                            if (cnt_reg < 3'd4)
                            begin
                                fs_reg[cnt_reg[1:0]] <= rx_byte;
                                cnt_reg <= cnt_reg + 3'd1;
                            end
                            else
                            begin
                                cnt_reg  <= 3'd0;
                                r_reg[0] <= 8'h00;
                                nres_reg <= 3'd1;
                                state_reg <= S_SEND;
                                step_reg <= 4'd0;
                                acc_reg  <= 34'd0;
                                case (rx_byte)
                                    OP_SET_FREQ: state_reg <= S_BCD;
                                    OP_SPLIT_ON:
                                    begin
                                        split_reg <= 1'b1;
                                        state_reg <= S_IDLE;
                                    end
                                    OP_SPLIT_OFF:
                                    begin
                                        split_reg <= 1'b0;
                                        state_reg <= S_IDLE;
                                    end
                                    OP_READ_FREQ:
                                    begin
                                        acc_reg  <= {4'd0, act_reg};
                                        dig_reg  <= 4'd0;
                                        state_reg <= S_DIG;
                                    end
                                    OP_MODE: usb_reg <= !(fs_reg[0] == 8'h00 ||
                                                          fs_reg[0] == 8'h03);
                                    OP_PTT_ON:
                                    begin
                                        if (tx_reg) r_reg[0] <= 8'hF0;
                                        tx_reg <= 1'b1;
                                    end
                                    OP_PTT_OFF: tx_reg <= 1'b0;
                                    OP_SWAP:
                                    begin
                                        act_reg  <= oth_reg;
                                        oth_reg  <= act_reg;
                                        vfob_reg <= !vfob_reg;
                                    end
                                    OP_SETTINGS:
                                    begin
                                        nres_reg <= 3'd2;
                                        {r_reg[0], r_reg[1]} <= settings(fs_reg[0], fs_reg[1]);
                                        if (fs_reg[1] == 8'h5E)
                                        begin
                                            acc_reg  <= {24'd0, tone_reg};
                                            quo_reg  <= 11'd0;
                                            dig_reg  <= 4'd0;
                                            state_reg <= S_DIV;
                                        end
                                        else if (fs_reg[1] == 8'h62)
                                        begin
                                            acc_reg  <= 34'd1200;
                                            quo_reg  <= 11'd0;
                                            dig_reg  <= 4'd1;
                                            state_reg <= S_DIV;
                                        end
                                    end
                                    OP_RX_STAT: r_reg[0] <= 8'h09;
                                    OP_TX_STAT: r_reg[0] <= {!tx_reg, 1'b0, split_reg,
                                                             5'b01000};
                                    default: r_reg[0] <= 8'h00;
                                endcase
                            end
                        end
                    end
                end
                // multiply-accumulate one BCD nibble per cycle
                S_BCD:
                begin
                    acc_reg  <= acc_reg + {3'd0, prod};
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd7)
                    begin
                        act_reg <= ((acc_reg + {3'd0, prod}) > {4'd0, FREQ_MAX}) ?
                                   FREQ_MAX : acc_reg[29:0] + prod[29:0];
                        state_reg <= S_SEND;
                    end
                end
                // digit extraction: subtract 10^(8-dig) repeatedly
                S_DIG:
                begin
                    if (dig_reg == 4'd9)
                    begin
                        r_reg[3] <= {d_reg[2], d_reg[1]};
                        r_reg[2] <= {d_reg[4], d_reg[3]};
                        r_reg[1] <= {d_reg[6], d_reg[5]};
                        r_reg[0] <= {d_reg[8], d_reg[7]};
                        r_reg[4] <= {7'd0, usb_reg};
                        nres_reg <= 3'd5;
                        state_reg <= S_SEND;
                    end
                    else if (dig_reg == 4'd8)
                    begin
                        d_reg[0] <= acc_reg[3:0];
                        dig_reg  <= 4'd9;
                    end
                    else
                    begin
                        if (ge && step_reg != 4'd9)
                        begin
                            acc_reg  <= diff;
                            step_reg <= step_reg + 4'd1;
                        end
                        else
                        begin
                            d_reg[4'd8 - dig_reg] <= step_reg;
                            step_reg <= 4'd0;
                            dig_reg  <= dig_reg + 4'd1;
                        end
                    end
                end
                // repeated subtraction divider: tone less 300 by 50, or 1200 by dot
                S_DIV:
                begin
                    if (dig_reg == 4'd0)
                    begin
                        if (acc_reg[10:0] < 11'd300)
                        begin
                            r_reg[0] <= 8'd0;
                            state_reg <= S_SEND;
                        end
                        else
                        begin
                            acc_reg <= acc_reg - 34'd300;
                            dig_reg <= 4'd2;
                        end
                    end
                    else
                    begin
                        logic [10:0] dv;
                        dv = (dig_reg == 4'd2) ? 11'd50 : {2'd0, dot_reg};
                        if (dig_reg == 4'd1 && dot_reg == 9'd0)
                        begin
                            r_reg[0] <= 8'hFF;
                            state_reg <= S_SEND;
                        end
                        else if (acc_reg[10:0] >= dv)
                        begin
                            acc_reg <= acc_reg - {23'd0, dv};
                            quo_reg <= quo_reg + 11'd1;
                        end
                        else
                        begin
                            if (dig_reg == 4'd2)
                                r_reg[0] <= quo_reg[7:0];
                            else if (quo_reg < 11'd4)
                                r_reg[0] <= 8'd0;
                            else if (quo_reg > 11'd259)
                                r_reg[0] <= 8'hFF;
                            else
                                r_reg[0] <= 8'(quo_reg - 11'd4);
                            state_reg <= S_SEND;
                        end
                    end
                end
                S_SEND:
                begin
                    if (out_ready)
                    begin
                        k_reg <= k_reg + 3'd1;
                        if (last_byte)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken during response");
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (k_reg < nres_reg)) else $error("response index overrun");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte) |=> in_ready)
        else $error("no return to idle after last byte");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("frame count overrun");
endmodule
